@@ design/assert_macros.svh @@
// Assertion macros shared by the voice allocator RTL.
// Each macro expands to one labeled concurrent assertion that reports by $error.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check an expression at every clock edge outside reset
`define SVA_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error(msg);

// Check a consequent in the same cycle as its antecedent
`define SVA_IMPLIES(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Check a consequent in the cycle after its antecedent
`define SVA_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/sva_pkg.sv @@
// Shared types, codes and constants of the voice allocator.
// Used by sva_cell, sva_ctrl and synth_voice_allocator; depends on nothing.
`timescale 1ns / 1ps

package sva_pkg;

    // Field widths
    localparam int VOICE_W = 5;
    localparam int STAMP_W = 32;
    localparam int NOTE_W  = 7;
    localparam int VNOTE_W = 8;
    localparam int CH_W    = 4;
    localparam int VEL_W   = 7;
    localparam int PL_W    = 6;
    localparam int LEVEL_W = 7;
    localparam int LP_W    = 2;
    localparam int CFG_W   = 5;

    localparam int DEF_NUM_VOICES = 18;

    // Reset values
    localparam logic [VNOTE_W-1:0] NOTE_FREE       = 8'hFF;
    localparam logic [STAMP_W-1:0] VOICE_STAMP_RST = 32'd1;
    localparam logic [STAMP_W-1:0] CUR_STAMP_RST   = 32'd2;
    localparam logic [CFG_W-1:0]   CFG_RST         = 5'd18;

    // Drum channel and its valid key range
    localparam logic [CH_W-1:0]   DRUM_CH    = 4'd9;
    localparam int                DRUM_COUNT = 47;
    localparam logic [NOTE_W-1:0] DRUM_LOW   = 7'd35;
    localparam logic [NOTE_W-1:0] DRUM_END   = NOTE_W'(35 + DRUM_COUNT);

    // Level scaling: frac = floor(v * 16384 / 25) through a reciprocal
    localparam logic [VEL_W-1:0]   VEL_MAX     = 7'd100;
    localparam logic [LEVEL_W-1:0] LEVEL_FULL  = 7'd64;
    localparam int                 T_W         = 21;
    localparam int                 T_SHIFT     = 14;
    localparam int                 RECIP_W     = 26;
    localparam logic [RECIP_W-1:0] FRAC_MUL    = 26'd42949673;
    localparam int                 FRAC_SHIFT  = 30;
    localparam int                 FRAC_W      = 17;
    localparam int                 FPROD_W     = T_W + RECIP_W;
    localparam int                 LPROD_W     = LEVEL_W + FRAC_W;
    localparam int                 LEVEL_SHIFT = 16;

    typedef enum logic [1:0] {
        FUNC_NOTE_ON,
        FUNC_NOTE_OFF,
        FUNC_PROGRAM,
        FUNC_ALL_OFF
    } func_t;

    typedef enum logic [1:0] {
        TOK_MIN,
        TOK_REL,
        TOK_OFF
    } tok_op_t;

    typedef enum logic [LP_W-1:0] {
        LP_NONE,
        LP_CHANNEL,
        LP_DRUM
    } lp_t;

    typedef enum logic {
        ACT_KEY_OFF,
        ACT_KEY_ON
    } action_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_SCAN,
        ST_STEAL,
        ST_WRITE,
        ST_FLUSH
    } state_t;

    // Token that travels down the cell chain, one cell per cycle unless the chain is stalled
    typedef struct packed {
        logic                valid;
        tok_op_t             op;
        logic                key_valid;
        logic [CH_W-1:0]     key_ch;
        logic [NOTE_W-1:0]   key_note;
        logic [STAMP_W-1:0]  stamp;
        logic                free_found;
        logic [STAMP_W-1:0]  free_stamp;
        logic [VOICE_W-1:0]  free_idx;
        logic [CH_W-1:0]     free_ch;
        logic                free_rel;
        logic                any_found;
        logic [STAMP_W-1:0]  any_stamp;
        logic [VOICE_W-1:0]  any_idx;
        logic [CH_W-1:0]     any_ch;
        logic                any_rel;
        logic                next_found;
        logic [CH_W-1:0]     next_ch;
        logic [NOTE_W-1:0]   next_note;
    } tok_t;

    // Commands sent to all cells at once while no token is in flight
    typedef struct packed {
        logic                wr_valid;
        logic [VOICE_W-1:0]  wr_idx;
        logic [NOTE_W-1:0]   wr_note;
        logic [CH_W-1:0]     wr_ch;
        logic [STAMP_W-1:0]  wr_stamp;
        logic                wr_reload;
        logic                rl_valid;
        logic                rl_all;
        logic [CH_W-1:0]     rl_ch;
    } bcast_t;

    // One result item
    typedef struct packed {
        action_t             action;
        logic [VOICE_W-1:0]  voice;
        logic [NOTE_W-1:0]   note;
        logic [LEVEL_W-1:0]  level;
        lp_t                 lp;
    } res_t;

endpackage

@@ design/sva_cell.sv @@
// One voice cell: holds note, channel, stamp and reload mark of a voice,
// and updates the token passing through it. Depends on sva_pkg.
`timescale 1ns / 1ps

module sva_cell #(
    parameter int CELL_IDX = 0
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            en,
    input  logic            adv,
    input  sva_pkg::tok_t   tok_in,
    output sva_pkg::tok_t   tok_out,
    input  sva_pkg::bcast_t bc,
    output logic            emit
);
    import sva_pkg::*;

    localparam logic [VOICE_W-1:0] MY_IDX = VOICE_W'(CELL_IDX);

    logic [VNOTE_W-1:0] note_reg;
    logic [CH_W-1:0]    ch_reg;
    logic [STAMP_W-1:0] stamp_reg;
    logic               reload_reg;
    tok_t               tok_reg;
    tok_t               tok_next;
    logic               is_free;
    logic               key_hit;

    assign is_free = note_reg[VNOTE_W-1];

    // Match the released key against this voice
    assign key_hit = en && tok_in.valid
                     && (tok_in.op == TOK_REL || (tok_in.op == TOK_OFF && tok_in.key_valid))
                     && ch_reg == tok_in.key_ch
                     && note_reg == {1'b0, tok_in.key_note};
    assign emit = key_hit;

    // Fold this voice into the passing token
    always_comb
    begin
        tok_next = tok_in;
        if (en && tok_in.valid)
        begin
            case (tok_in.op)
                TOK_MIN:
                begin
                    if (is_free && (!tok_in.free_found || stamp_reg < tok_in.free_stamp))
                    begin
                        tok_next.free_found = 1'b1;
                        tok_next.free_stamp = stamp_reg;
                        tok_next.free_idx   = MY_IDX;
                        tok_next.free_ch    = ch_reg;
                        tok_next.free_rel   = reload_reg;
                    end
                    if (!tok_in.any_found || stamp_reg < tok_in.any_stamp)
                    begin
                        tok_next.any_found = 1'b1;
                        tok_next.any_stamp = stamp_reg;
                        tok_next.any_idx   = MY_IDX;
                        tok_next.any_ch    = ch_reg;
                        tok_next.any_rel   = reload_reg;
                    end
                end
                TOK_REL:
                begin
                    if (key_hit)
                        tok_next.stamp = tok_in.stamp + 1'b1;
                end
                TOK_OFF:
                begin
                    if (key_hit)
                        tok_next.stamp = tok_in.stamp + 1'b1;
                    else if (!is_free && !tok_in.next_found)
                    begin
                        tok_next.next_found = 1'b1;
                        tok_next.next_ch    = ch_reg;
                        tok_next.next_note  = note_reg[NOTE_W-1:0];
                    end
                end
                default:
                begin
                    tok_next = tok_in;
                end
            endcase
        end
    end

    // Advance the token to the next cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tok_reg <= '0;
        else if (adv)
            tok_reg <= tok_next;
    end

    assign tok_out = tok_reg;

    // Update the voice state on release, write and reload marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            note_reg   <= NOTE_FREE;
            ch_reg     <= '0;
            stamp_reg  <= VOICE_STAMP_RST;
            reload_reg <= 1'b0;
        end
        else
        begin
            if (adv && key_hit)
            begin
                note_reg  <= NOTE_FREE;
                stamp_reg <= tok_in.stamp;
            end
            if (bc.wr_valid && bc.wr_idx == MY_IDX)
            begin
                note_reg   <= {1'b0, bc.wr_note};
                ch_reg     <= bc.wr_ch;
                stamp_reg  <= bc.wr_stamp;
                reload_reg <= bc.wr_reload;
            end
            if (bc.rl_valid && en && (bc.rl_all || ch_reg == bc.rl_ch))
                reload_reg <= 1'b1;
        end
    end

endmodule

@@ design/sva_ctrl.sv @@
// Sequencer of the voice allocator: request intake, config register, level
// scaling, token launch and the output stage. Depends on sva_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module sva_ctrl #(
    parameter int NUM_VOICES = sva_pkg::DEF_NUM_VOICES
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [23:0]             s_tdata,
    input  logic [1:0]              s_tuser,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [23:0]             m_tdata,
    output logic [0:0]              m_tuser,
    output logic                    m_tlast,
    input  logic                    cfg_valid,
    output logic                    cfg_ready,
    input  logic [sva_pkg::CFG_W-1:0] cfg_data,
    output sva_pkg::tok_t           launch,
    input  sva_pkg::tok_t           ret,
    output logic                    adv,
    input  logic [NUM_VOICES-1:0]   emit,
    output logic [NUM_VOICES-1:0]   en_mask,
    output sva_pkg::bcast_t         bc
);
    import sva_pkg::*;

    localparam int CNT_W = $clog2(NUM_VOICES + 1);

    state_t              state_reg;
    state_t              state_next;
    logic [CFG_W-1:0]    cfg_reg;
    logic [CNT_W-1:0]    n_act;

    func_t               func_reg;
    logic [CH_W-1:0]     ch_reg;
    logic [NOTE_W-1:0]   note_reg;
    logic [VEL_W-1:0]    vel_reg;
    logic [PL_W-1:0]     pl_reg;

    logic [VEL_W-1:0]    vel_sat;
    logic [FPROD_W-1:0]  frac_prod;
    logic [FRAC_W-1:0]   frac_reg;
    logic [LEVEL_W-1:0]  atten;
    logic [LPROD_W-1:0]  level_prod;
    logic [LEVEL_W-1:0]  level_reg;

    logic [STAMP_W-1:0]  cur_stamp_reg;
    logic                cur_inc;
    logic [VOICE_W-1:0]  sel_idx_reg;
    logic [CH_W-1:0]     sel_ch_reg;
    logic                sel_rel_reg;
    logic                sel_load;

    tok_t                launch_reg;
    tok_t                launch_val;
    logic                launch_go;

    logic                drum;
    logic                drum_bad;
    logic                emit_any;
    logic [VOICE_W-1:0]  emit_idx;

    logic                out_free;
    logic                can_push;
    logic                cell_push;
    logic                ctl_push;
    res_t                ctl_res;
    logic                push;
    res_t                push_res;
    logic                flush;
    logic                out_load;

    logic                pend_valid_reg;
    logic                pend_valid_next;
    res_t                pend_res_reg;
    logic                out_valid_reg;
    logic                out_valid_next;
    res_t                out_res_reg;
    logic                out_last_reg;

    // Configuration register, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cfg_reg <= CFG_RST;
        else if (cfg_valid && cfg_ready)
            cfg_reg <= cfg_data;
    end

    // Clamp the voice count and mark the cells in use
    always_comb
    begin
        if (cfg_reg == '0)
            n_act = CNT_W'(1);
        else if (int'(cfg_reg) > NUM_VOICES)
            n_act = CNT_W'(NUM_VOICES);
        else
            n_act = CNT_W'(cfg_reg);
        for (int i = 0; i < NUM_VOICES; i++)
            en_mask[i] = CNT_W'(i) < n_act;
    end

    // Hold the accepted request
    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            func_reg <= func_t'(s_tuser);
            ch_reg   <= s_tdata[3:0];
            note_reg <= s_tdata[10:4];
            vel_reg  <= s_tdata[17:11];
            pl_reg   <= s_tdata[23:18];
        end
    end

    // Scale level: frac by reciprocal multiply, then by (64 - attenuation)
    assign vel_sat    = (vel_reg > VEL_MAX) ? VEL_MAX : vel_reg;
    assign frac_prod  = FPROD_W'({vel_sat, {T_SHIFT{1'b0}}}) * FPROD_W'(FRAC_MUL);
    assign atten      = LEVEL_FULL - {1'b0, pl_reg};
    assign level_prod = LPROD_W'(atten) * LPROD_W'(frac_reg);

    always_ff @(posedge clk)
    begin
        frac_reg  <= frac_prod[FRAC_SHIFT +: FRAC_W];
        level_reg <= level_prod[LEVEL_SHIFT +: LEVEL_W];
    end

    assign drum     = ch_reg == DRUM_CH;
    assign drum_bad = drum && (note_reg < DRUM_LOW || note_reg >= DRUM_END);

    // Encode the emitting cell; at most one holds the token
    always_comb
    begin
        emit_idx = '0;
        for (int i = 0; i < NUM_VOICES; i++)
            if (emit[i])
                emit_idx = emit_idx | VOICE_W'(i);
    end
    assign emit_any = |emit;

    // Output stage flow
    assign out_free  = !out_valid_reg || m_tready;
    assign can_push  = !pend_valid_reg || out_free;
    assign adv       = !(emit_any && !can_push);
    assign cell_push = emit_any && can_push;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
                if (s_tvalid)
                    state_next = ST_START;
            ST_START:
                if ((func_reg == FUNC_NOTE_ON && vel_reg != '0 && drum_bad)
                    || func_reg == FUNC_PROGRAM)
                    state_next = ST_FLUSH;
                else
                    state_next = ST_SCAN;
            ST_SCAN:
                if (ret.valid)
                begin
                    if (ret.op == TOK_MIN)
                        state_next = ret.free_found ? ST_WRITE : ST_STEAL;
                    else if (ret.op == TOK_OFF && ret.next_found)
                        state_next = ST_SCAN;
                    else
                        state_next = ST_FLUSH;
                end
            ST_STEAL:
                if (can_push)
                    state_next = ST_WRITE;
            ST_WRITE:
                if (level_reg == '0 || can_push)
                    state_next = ST_FLUSH;
            ST_FLUSH:
                if (!pend_valid_reg || out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        s_tready   = state_reg == ST_IDLE;
        launch_go  = 1'b0;
        launch_val = '0;
        launch_val.valid = 1'b1;
        launch_val.stamp = cur_stamp_reg;
        bc         = '0;
        ctl_push   = 1'b0;
        ctl_res    = '0;
        flush      = 1'b0;
        cur_inc    = 1'b0;
        sel_load   = 1'b0;
        case (state_reg)
            ST_START:
            begin
                case (func_reg)
                    FUNC_NOTE_ON:
                    begin
                        if (vel_reg == '0)
                        begin
                            launch_go            = 1'b1;
                            launch_val.op        = TOK_REL;
                            launch_val.key_valid = 1'b1;
                            launch_val.key_ch    = ch_reg;
                            launch_val.key_note  = note_reg;
                        end
                        else if (!drum_bad)
                        begin
                            launch_go     = 1'b1;
                            launch_val.op = TOK_MIN;
                        end
                    end
                    FUNC_NOTE_OFF:
                    begin
                        launch_go            = 1'b1;
                        launch_val.op        = TOK_REL;
                        launch_val.key_valid = 1'b1;
                        launch_val.key_ch    = ch_reg;
                        launch_val.key_note  = note_reg;
                    end
                    FUNC_PROGRAM:
                    begin
                        bc.rl_valid = 1'b1;
                        bc.rl_ch    = ch_reg;
                    end
                    FUNC_ALL_OFF:
                    begin
                        bc.rl_valid   = 1'b1;
                        bc.rl_all     = 1'b1;
                        launch_go     = 1'b1;
                        launch_val.op = TOK_OFF;
                    end
                    default:
                    begin
                        launch_go = 1'b0;
                    end
                endcase
            end
            ST_SCAN:
            begin
                if (ret.valid && ret.op == TOK_MIN)
                    sel_load = 1'b1;
                // Release the next key group with the stamp carried back
                if (ret.valid && ret.op == TOK_OFF && ret.next_found)
                begin
                    launch_go            = 1'b1;
                    launch_val.op        = TOK_OFF;
                    launch_val.key_valid = 1'b1;
                    launch_val.key_ch    = ret.next_ch;
                    launch_val.key_note  = ret.next_note;
                    launch_val.stamp     = ret.stamp;
                end
            end
            ST_STEAL:
            begin
                if (can_push)
                begin
                    ctl_push       = 1'b1;
                    ctl_res.action = ACT_KEY_OFF;
                    ctl_res.voice  = sel_idx_reg;
                    ctl_res.lp     = LP_NONE;
                    cur_inc        = 1'b1;
                end
            end
            ST_WRITE:
            begin
                if (level_reg != '0 && can_push)
                begin
                    ctl_push       = 1'b1;
                    ctl_res.action = ACT_KEY_ON;
                    ctl_res.voice  = sel_idx_reg;
                    ctl_res.note   = note_reg;
                    ctl_res.level  = level_reg;
                    if (drum)
                        ctl_res.lp = LP_DRUM;
                    else if (sel_ch_reg != ch_reg || sel_rel_reg)
                        ctl_res.lp = LP_CHANNEL;
                    else
                        ctl_res.lp = LP_NONE;
                    bc.wr_valid  = 1'b1;
                    bc.wr_idx    = sel_idx_reg;
                    bc.wr_note   = note_reg;
                    bc.wr_ch     = ch_reg;
                    bc.wr_stamp  = cur_stamp_reg;
                    bc.wr_reload = drum;
                    cur_inc      = 1'b1;
                end
            end
            ST_FLUSH:
            begin
                flush = pend_valid_reg && out_free;
            end
            default:
            begin
                flush = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Running stamp: take it back from a release pass, or bump it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cur_stamp_reg <= CUR_STAMP_RST;
        else if (state_reg == ST_SCAN && ret.valid && ret.op != TOK_MIN)
            cur_stamp_reg <= ret.stamp;
        else if (cur_inc)
            cur_stamp_reg <= cur_stamp_reg + 1'b1;
    end

    // Hold the chosen voice of a note-on
    always_ff @(posedge clk)
    begin
        if (sel_load)
        begin
            sel_idx_reg <= ret.free_found ? ret.free_idx : ret.any_idx;
            sel_ch_reg  <= ret.free_found ? ret.free_ch  : ret.any_ch;
            sel_rel_reg <= ret.free_found ? ret.free_rel : ret.any_rel;
        end
    end

    // Launch slot ahead of the first cell
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            launch_reg <= '0;
        else if (launch_go)
            launch_reg <= launch_val;
        else if (adv)
            launch_reg.valid <= 1'b0;
    end

    assign launch = launch_reg;

    // Result source: a releasing cell or the sequencer
    always_comb
    begin
        push     = cell_push || ctl_push;
        push_res = ctl_res;
        if (cell_push)
        begin
            push_res        = '0;
            push_res.action = ACT_KEY_OFF;
            push_res.voice  = emit_idx;
            push_res.lp     = LP_NONE;
        end
    end

    // Pending slot holds the newest result until its last flag is known
    assign out_load        = (push && pend_valid_reg) || flush;
    assign pend_valid_next = push ? 1'b1 : (flush ? 1'b0 : pend_valid_reg);
    assign out_valid_next  = out_load ? 1'b1 : (m_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            pend_res_reg <= push_res;
        if (out_load)
        begin
            out_res_reg  <= pend_res_reg;
            out_last_reg <= flush;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_res_reg.action;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = {3'b000, out_res_reg.lp, out_res_reg.level,
                       out_res_reg.note, out_res_reg.voice};

    `SVA_IMPLIES(a_idle_no_pend, clk, rst_n, state_reg == ST_IDLE, !pend_valid_reg, "result left pending in idle")
    `SVA_IMPLIES(a_emit_in_scan, clk, rst_n, emit_any, state_reg == ST_SCAN, "cell release outside a scan")
    `SVA_NEXT(a_flush_done, clk, rst_n, flush, state_reg == ST_IDLE && out_last_reg, "final result not closing the request")

endmodule

@@ design/synth_voice_allocator.sv @@
// Top level of the polyphonic voice allocator: a chain of voice cells and
// the sequencer that drives it. Depends on sva_pkg, sva_cell, sva_ctrl, assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Voice allocator with least-recently-changed selection and voice stealing.
// Each voice lives in a cell of a chain; a request sends a token down the
// chain one cell per clock, and a stall on the result side holds the token
// in place. All-notes-off runs one pass per distinct active key plus one.
// Program change sends no token down the chain. A new request is taken only
// when the previous one has passed all its results to the output register;
// results leave through a registered output with one pending slot, so tlast
// marks the final result of each request. No clearing pass after reset.
module synth_voice_allocator #(
    parameter int NUM_VOICES = sva_pkg::DEF_NUM_VOICES
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,    // midi_channel[3:0], note[10:4], velocity[17:11],
                                    // patch_level[23:18]
    input  logic [1:0]  s_tuser,    // func[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,    // voice[4:0], note_out[11:5], level[18:12],
                                    // load_patch[20:19], zero fill above
    output logic [0:0]  m_tuser,    // action[0]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [4:0]  cfg_data    // voices_in_use
);
    import sva_pkg::*;

    tok_t                  tok_chain [NUM_VOICES+1];
    logic [NUM_VOICES:0]   tok_valid;
    logic                  adv;
    logic [NUM_VOICES-1:0] emit;
    logic [NUM_VOICES-1:0] en_mask;
    bcast_t                bc;

    sva_ctrl #(
        .NUM_VOICES (NUM_VOICES)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .launch    (tok_chain[0]),
        .ret       (tok_chain[NUM_VOICES]),
        .adv       (adv),
        .emit      (emit),
        .en_mask   (en_mask),
        .bc        (bc)
    );

    // Chain of voice cells
    for (genvar i = 0; i < NUM_VOICES; i++)
    begin : g_cell
        sva_cell #(
            .CELL_IDX (i)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en_mask[i]),
            .adv     (adv),
            .tok_in  (tok_chain[i]),
            .tok_out (tok_chain[i+1]),
            .bc      (bc),
            .emit    (emit[i])
        );
    end

    // Collect token valids for the single-token check
    always_comb
    begin
        for (int i = 0; i <= NUM_VOICES; i++)
            tok_valid[i] = tok_chain[i].valid;
    end

    `SVA_ALWAYS(a_one_token, clk, rst_n, $onehot0(tok_valid), "more than one token in the chain")

endmodule

@@ tb/synth_voice_allocator_tb.sv @@
// Self-checking testbench for the polyphonic voice allocator.
// Needs sva_pkg and synth_voice_allocator; drives the request stream and the voice-count
// channel and checks every voice action against a behavioral allocator or a typed result.
`timescale 1ns / 1ps

module synth_voice_allocator_tb;

    import sva_pkg::*;

    localparam int NV              = DEF_NUM_VOICES;
    localparam int USE_MODEL       = -1;
    localparam int NO_RESULT       = 0;
    localparam int ONE_RESULT      = 1;
    localparam int SETTLE_CYCLES   = 100;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int RANDOM_PHASES   = 5;
    localparam int ITEMS_PER_PHASE = 26;
    localparam int VEL_SCALE       = 65536;
    localparam int HELD_MAX        = 32;

    // One voice action as it leaves the block
    typedef struct packed {
        action_t             action;
        logic [VOICE_W-1:0]  voice;
        logic [NOTE_W-1:0]   note;
        logic [LEVEL_W-1:0]  level;
        lp_t                 lp;
        logic                last;
    } voice_res_t;

    // One row of stimulus: a voice-count write or a request
    typedef struct {
        bit                  is_cfg;
        logic [CFG_W-1:0]    cfg_val;
        func_t               func;
        logic [CH_W-1:0]     chan;
        logic [NOTE_W-1:0]   note;
        logic [VEL_W-1:0]    vel;
        logic [PL_W-1:0]     plev;
        int                  n_typed;
        voice_res_t          typed;
    } stim_row_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;
    logic [1:0]  s_tuser   = '0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;
    logic [0:0]  m_tuser;
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [4:0]  cfg_data  = '0;

    // Behavioral allocator state
    logic [VNOTE_W-1:0] v_note   [NV];
    logic [CH_W-1:0]    v_chan   [NV];
    logic [STAMP_W-1:0] v_stamp  [NV];
    logic               v_reload [NV];
    logic [STAMP_W-1:0] stamp_now;
    logic [CFG_W-1:0]   voices_cfg;

    voice_res_t event_actions[$];
    voice_res_t awaited_actions[$];
    stim_row_t  sent_events[$];
    stim_row_t  directed_events[$];
    logic [10:0] held_keys[$];

    bit calm = 1'b0;
    int mismatches   = 0;
    int requests     = 0;
    int actions_seen = 0;
    int cfg_writes   = 0;
    int quiet_cycles = 0;

    synth_voice_allocator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // ---------------------------------------------------------------- allocator
    function automatic int scan_limit();
        if (voices_cfg == 0)
            return 1;
        if (voices_cfg > NV)
            return NV;
        return int'(voices_cfg);
    endfunction

    function automatic void add_action(action_t a, int v, int nt, int lvl, lp_t lp);
        voice_res_t r;
        r.action = a;
        r.voice  = VOICE_W'(v);
        r.note   = NOTE_W'(nt);
        r.level  = LEVEL_W'(lvl);
        r.lp     = lp;
        r.last   = 1'b0;
        event_actions.push_back(r);
    endfunction

    // Key off every voice holding this key on this channel
    function automatic void release_key(logic [CH_W-1:0] ch, logic [VNOTE_W-1:0] nt);
        int n;
        n = scan_limit();
        for (int i = 0; i < n; i++)
        begin
            if (v_chan[i] == ch && v_note[i] == nt)
            begin
                add_action(ACT_KEY_OFF, i, 0, 0, LP_NONE);
                v_stamp[i] = stamp_now;
                stamp_now++;
                v_note[i] = NOTE_FREE;
            end
        end
    endfunction

    function automatic void start_note(logic [CH_W-1:0] ch, logic [NOTE_W-1:0] nt,
                                       logic [VEL_W-1:0] vel, logic [PL_W-1:0] pl);
        int  n;
        int  pick;
        int  vcl;
        int  frac;
        int  lvl;
        bit  found;
        lp_t lp;
        n     = scan_limit();
        pick  = 0;
        found = 1'b0;
        // drop drum keys outside the kit
        if (ch == DRUM_CH && (nt < DRUM_LOW || nt >= DRUM_END))
            return;
        // oldest free voice, lowest index on a tie
        for (int i = 0; i < n; i++)
        begin
            if (v_note[i][VNOTE_W-1] && (!found || v_stamp[i] < v_stamp[pick]))
            begin
                pick  = i;
                found = 1'b1;
            end
        end
        // nothing free: steal the oldest voice
        if (!found)
        begin
            for (int i = 0; i < n; i++)
            begin
                if (!found || v_stamp[i] < v_stamp[pick])
                begin
                    pick  = i;
                    found = 1'b1;
                end
            end
            add_action(ACT_KEY_OFF, pick, 0, 0, LP_NONE);
            stamp_now++;
        end
        vcl  = (vel > VEL_MAX) ? int'(VEL_MAX) : int'(vel);
        frac = (vcl * VEL_SCALE) / int'(VEL_MAX);
        lvl  = ((int'(LEVEL_FULL) - int'(pl)) * frac) >> LEVEL_SHIFT;
        if (lvl == 0)
            return;
        v_stamp[pick] = stamp_now;
        stamp_now++;
        lp = LP_NONE;
        if (ch == DRUM_CH)
        begin
            lp = LP_DRUM;
            v_reload[pick] = 1'b1;
        end
        else if (v_chan[pick] != ch || v_reload[pick])
        begin
            lp = LP_CHANNEL;
            v_reload[pick] = 1'b0;
        end
        v_note[pick] = {1'b0, nt};
        v_chan[pick] = ch;
        add_action(ACT_KEY_ON, pick, nt, lvl, lp);
    endfunction

    // Work out the voice actions caused by one request
    function automatic void allocate_event(func_t f, logic [CH_W-1:0] ch,
                                           logic [NOTE_W-1:0] nt, logic [VEL_W-1:0] vel,
                                           logic [PL_W-1:0] pl);
        int         n;
        voice_res_t tail;
        n = scan_limit();
        event_actions.delete();
        case (f)
            FUNC_NOTE_ON:
                if (vel == 0)
                    release_key(ch, {1'b0, nt});
                else
                    start_note(ch, nt, vel, pl);
            FUNC_NOTE_OFF:
                release_key(ch, {1'b0, nt});
            FUNC_PROGRAM:
                for (int i = 0; i < n; i++)
                    if (v_chan[i] == ch)
                        v_reload[i] = 1'b1;
            default:
            begin
                for (int i = 0; i < n; i++)
                    v_reload[i] = 1'b1;
                for (int i = 0; i < n; i++)
                    if (!v_note[i][VNOTE_W-1])
                        release_key(v_chan[i], v_note[i]);
            end
        endcase
        // mark the final action
        if (event_actions.size() > 0)
        begin
            tail = event_actions.pop_back();
            tail.last = 1'b1;
            event_actions.push_back(tail);
        end
    endfunction

    // ---------------------------------------------------------------- row builders
    function automatic stim_row_t ev(func_t f, logic [CH_W-1:0] ch, logic [NOTE_W-1:0] nt,
                                     logic [VEL_W-1:0] vel, logic [PL_W-1:0] pl,
                                     int n_typed, voice_res_t typed);
        stim_row_t r;
        r.is_cfg  = 1'b0;
        r.cfg_val = '0;
        r.func    = f;
        r.chan    = ch;
        r.note    = nt;
        r.vel     = vel;
        r.plev    = pl;
        r.n_typed = n_typed;
        r.typed   = typed;
        return r;
    endfunction

    function automatic stim_row_t set_voices(logic [CFG_W-1:0] val);
        stim_row_t r;
        r = ev(FUNC_PROGRAM, '0, '0, '0, '0, NO_RESULT, '0);
        r.is_cfg  = 1'b1;
        r.cfg_val = val;
        return r;
    endfunction

    function automatic voice_res_t key_on(int v, int nt, int lvl, lp_t lp);
        voice_res_t r;
        r.action = ACT_KEY_ON;
        r.voice  = VOICE_W'(v);
        r.note   = NOTE_W'(nt);
        r.level  = LEVEL_W'(lvl);
        r.lp     = lp;
        r.last   = 1'b1;
        return r;
    endfunction

    function automatic voice_res_t key_off(int v);
        voice_res_t r;
        r = key_on(v, 0, 0, LP_NONE);
        r.action = ACT_KEY_OFF;
        return r;
    endfunction

    // ---------------------------------------------------------------- random requests
    function automatic logic [10:0] take_held();
        int          k;
        logic [10:0] key;
        k   = $urandom_range(0, held_keys.size() - 1);
        key = held_keys[k];
        held_keys.delete(k);
        return key;
    endfunction

    // Mostly note-on / note-off pairs on a few busy channels, the rest noise
    function automatic stim_row_t draw_event();
        stim_row_t   r;
        int          pick;
        int          k;
        logic [10:0] key;
        r = ev(FUNC_NOTE_ON, CH_W'($urandom_range(0, 15)), NOTE_W'($urandom_range(0, 127)),
               VEL_W'($urandom_range(0, 127)), PL_W'($urandom_range(0, 63)), USE_MODEL, '0);
        pick = $urandom_range(0, 99);
        if (pick < 50)
        begin
            if ($urandom_range(0, 9) < 7)
            begin
                case ($urandom_range(0, 3))
                    0:       r.chan = 4'd0;
                    1:       r.chan = 4'd1;
                    2:       r.chan = 4'd2;
                    default: r.chan = DRUM_CH;
                endcase
            end
            if (r.chan == DRUM_CH)
                r.note = NOTE_W'($urandom_range(30, 86));
            else if ($urandom_range(0, 9) < 6)
                r.note = NOTE_W'($urandom_range(56, 67));
            k = $urandom_range(0, 9);
            if (k == 0)
                r.vel = VEL_W'($urandom_range(1, 3));
            else if (k == 1 && held_keys.size() > 0)
            begin
                key    = take_held();
                r.chan = key[10:7];
                r.note = key[6:0];
                r.vel  = '0;
            end
            if (r.vel != 0)
            begin
                held_keys.push_back({r.chan, r.note});
                if (held_keys.size() > HELD_MAX)
                    held_keys.delete(0);
            end
        end
        else if (pick < 78)
        begin
            r.func = FUNC_NOTE_OFF;
            if (held_keys.size() > 0 && $urandom_range(0, 4) != 0)
            begin
                key    = take_held();
                r.chan = key[10:7];
                r.note = key[6:0];
            end
        end
        else if (pick < 88)
            r.func = FUNC_PROGRAM;
        else if (pick < 93)
            r.func = FUNC_ALL_OFF;
        else
        begin
            // drum key outside the kit
            r.chan = DRUM_CH;
            r.note = $urandom_range(0, 1) ? NOTE_W'($urandom_range(0, 34))
                                          : NOTE_W'($urandom_range(82, 127));
        end
        return r;
    endfunction

    // ---------------------------------------------------------------- drivers
    task automatic send_event(stim_row_t r);
        int gap;
        gap = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sent_events.push_back(r);
        s_tvalid <= 1'b1;
        s_tuser  <= r.func;
        s_tdata  <= {r.plev, r.vel, r.note, r.chan};
        do @(posedge clk); while (!s_tready);
    endtask

    // Hold off until every action is in, then let a silent request finish
    task automatic settle();
        s_tvalid <= 1'b0;
        while (awaited_actions.size() != 0 || sent_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_voices(logic [CFG_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // Result side: random stall before each action
    initial
    begin : result_sink
        int stall;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = (calm || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
        end
    end

    // ---------------------------------------------------------------- checking
    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge clk)
    begin : scoreboard
        voice_res_t want;
        stim_row_t  sent;
        if (rst_n)
        begin
            // track the voice count
            if (cfg_valid && cfg_ready)
            begin
                voices_cfg = cfg_data;
                cfg_writes++;
            end

            // compare each voice action with the oldest expectation
            if (m_tvalid && m_tready)
            begin
                actions_seen++;
                if (awaited_actions.size() == 0)
                begin
                    $display("%0t: unexpected action %0d on voice %0d, note %0d, level %0d",
                             $time, m_tuser[0], m_tdata[4:0], m_tdata[11:5], m_tdata[18:12]);
                    mismatches++;
                end
                else
                begin
                    want = awaited_actions.pop_front();
                    check_field("action", want.action, m_tuser[0]);
                    check_field("voice", want.voice, m_tdata[4:0]);
                    check_field("note", want.note, m_tdata[11:5]);
                    check_field("level", want.level, m_tdata[18:12]);
                    check_field("load_patch", want.lp, m_tdata[20:19]);
                    check_field("last", want.last, m_tlast);
                end
            end

            // predict the actions of each accepted request
            if (s_tvalid && s_tready)
            begin
                requests++;
                allocate_event(func_t'(s_tuser), s_tdata[3:0], s_tdata[10:4],
                               s_tdata[17:11], s_tdata[23:18]);
                sent = sent_events.pop_front();
                if (sent.n_typed == USE_MODEL)
                    foreach (event_actions[i])
                        awaited_actions.push_back(event_actions[i]);
                else if (sent.n_typed == ONE_RESULT)
                    awaited_actions.push_back(sent.typed);
            end

            // watchdog on handshakes
            if ((cfg_valid && cfg_ready) || (m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no handshake for %0d cycles, %0d actions outstanding",
                         $time, quiet_cycles, awaited_actions.size());
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // ---------------------------------------------------------------- stimulus
    initial
    begin : stimulus
        logic [CFG_W-1:0] phase_voices [RANDOM_PHASES];
        int               directed;

        // allocator state after reset
        for (int i = 0; i < NV; i++)
        begin
            v_note[i]   = NOTE_FREE;
            v_chan[i]   = '0;
            v_stamp[i]  = VOICE_STAMP_RST;
            v_reload[i] = 1'b0;
        end
        stamp_now  = CUR_STAMP_RST;
        voices_cfg = CFG_RST;
        directed   = 0;

        // directed requests; a zero count means no action at all
        directed_events.push_back(ev(FUNC_NOTE_ON, 4'd0, 7'd60, 7'd127, 6'd0,
                                     ONE_RESULT, key_on(0, 60, 64, LP_NONE)));
        directed_events.push_back(ev(FUNC_NOTE_ON, DRUM_CH, 7'd34, 7'd64, 6'd10, NO_RESULT, '0));
        directed_events.push_back(ev(FUNC_NOTE_ON, DRUM_CH, 7'd82, 7'd127, 6'd0, NO_RESULT, '0));
        directed_events.push_back(ev(FUNC_NOTE_ON, DRUM_CH, 7'd35, 7'd100, 6'd63,
                                     ONE_RESULT, key_on(1, 35, 1, LP_DRUM)));
        directed_events.push_back(ev(FUNC_NOTE_ON, DRUM_CH, 7'd81, 7'd1, 6'd0, NO_RESULT, '0));
        directed_events.push_back(ev(FUNC_NOTE_ON, 4'd15, 7'd127, 7'd127, 6'd0,
                                     ONE_RESULT, key_on(2, 127, 64, LP_CHANNEL)));
        directed_events.push_back(ev(FUNC_NOTE_ON, 4'd3, 7'd0, 7'd99, 6'd63, NO_RESULT, '0));
        directed_events.push_back(ev(FUNC_NOTE_OFF, 4'd0, 7'd60, 7'd0, 6'd0,
                                     ONE_RESULT, key_off(0)));
        directed_events.push_back(ev(FUNC_NOTE_OFF, 4'd0, 7'd60, 7'd0, 6'd0, NO_RESULT, '0));
        directed_events.push_back(ev(FUNC_PROGRAM, DRUM_CH, 7'd5, 7'd5, 6'd5, NO_RESULT, '0));
        directed_events.push_back(ev(FUNC_NOTE_ON, DRUM_CH, 7'd35, 7'd50, 6'd32, USE_MODEL, '0));
        directed_events.push_back(ev(FUNC_NOTE_ON, 4'd5, 7'd64, 7'd80, 6'd20, USE_MODEL, '0));
        directed_events.push_back(ev(FUNC_NOTE_ON, 4'd5, 7'd64, 7'd0, 6'd0, USE_MODEL, '0));
        directed_events.push_back(ev(FUNC_NOTE_ON, 4'd15, 7'd127, 7'd127, 6'd5, USE_MODEL, '0));
        directed_events.push_back(ev(FUNC_PROGRAM, 4'd15, 7'd0, 7'd0, 6'd0, NO_RESULT, '0));
        directed_events.push_back(ev(FUNC_NOTE_OFF, 4'd15, 7'd127, 7'd127, 6'd63, USE_MODEL, '0));
        directed_events.push_back(ev(FUNC_NOTE_ON, 4'd0, 7'd127, 7'd127, 6'd0, USE_MODEL, '0));
        directed_events.push_back(ev(FUNC_ALL_OFF, 4'd7, 7'd99, 7'd33, 6'd17, USE_MODEL, '0));
        directed_events.push_back(ev(FUNC_ALL_OFF, 4'd0, 7'd0, 7'd0, 6'd0, NO_RESULT, '0));
        // a single voice: every further note-on steals
        directed_events.push_back(set_voices(5'd1));
        directed_events.push_back(ev(FUNC_NOTE_ON, 4'd2, 7'd10, 7'd127, 6'd0, USE_MODEL, '0));
        directed_events.push_back(ev(FUNC_NOTE_ON, 4'd2, 7'd11, 7'd127, 6'd63, USE_MODEL, '0));
        directed_events.push_back(ev(FUNC_NOTE_ON, 4'd2, 7'd12, 7'd1, 6'd0, USE_MODEL, '0));
        directed_events.push_back(set_voices(5'd0));
        directed_events.push_back(ev(FUNC_NOTE_ON, 4'd4, 7'd100, 7'd100, 6'd0, USE_MODEL, '0));
        directed_events.push_back(set_voices(5'd31));
        directed_events.push_back(ev(FUNC_ALL_OFF, 4'd15, 7'd127, 7'd127, 6'd63, USE_MODEL, '0));

        phase_voices[0] = CFG_RST;
        phase_voices[1] = CFG_W'($urandom_range(2, 17));
        phase_voices[2] = 5'd0;
        phase_voices[3] = 5'd31;
        phase_voices[4] = CFG_W'($urandom_range(0, 31));

        // hold reset low, then release it
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // walk the directed table
        foreach (directed_events[i])
        begin
            if (directed_events[i].is_cfg)
            begin
                settle();
                write_voices(directed_events[i].cfg_val);
            end
            else
            begin
                send_event(directed_events[i]);
                directed++;
            end
        end

        // random phases, each under its own voice count; one with no idling
        for (int p = 0; p < RANDOM_PHASES; p++)
        begin
            settle();
            write_voices(phase_voices[p]);
            calm = (p == 2);
            for (int k = 0; k < ITEMS_PER_PHASE; k++)
                send_event(draw_event());
        end
        calm = 1'b0;
        settle();

        $display("Covered %0d requests (%0d directed) and checked %0d voice actions",
                 requests, directed, actions_seen);
        $display("Voice count written %0d times, out-of-range counts included", cfg_writes);
        if (mismatches == 0 && awaited_actions.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
